FILE: src/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Shared types, microcode program and round helpers for the digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    typedef logic [31:0] word_t;
    typedef logic [3:0]  step_t;
    typedef logic [6:0]  round_t;

    localparam int unsigned SCHED_DEPTH = 16;
    localparam int unsigned CHAIN_DEPTH = 5;

    localparam logic [4:0] BLOCK_WORDS     = 5'd16;
    localparam logic [4:0] FILL_STOP_WORDS = 5'd14;   // 56 bytes: room for length
    localparam round_t     LAST_ROUND      = 7'd79;
    localparam round_t     LOAD_ROUNDS     = 7'd16;
    localparam logic [2:0] MAX_BYTES       = 3'd4;
    localparam logic [2:0] LAST_INDEX      = 3'd4;
    localparam word_t      PAD_WORD        = 32'h8000_0000;

    localparam word_t SHA1_IV [CHAIN_DEPTH] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACC,      // take one input word, merge its bytes
        OP_PAD80,    // merge the 0x80 marker byte
        OP_ZWORD,    // close the open word with zero bytes
        OP_LEN_HI,
        OP_LEN_LO,
        OP_LOAD,     // a..e from chain
        OP_ROUND,
        OP_ADD,      // chain += a..e
        OP_OUT       // emit digest words
    } op_t;

    typedef enum logic [3:0] {
        CD_NEXT,
        CD_JUMP,
        CD_WAIT_IN,
        CD_CALL_FULL,
        CD_JMP_NOT_LAST,
        CD_JMP_FILL56,
        CD_LOOP_ROUND,
        CD_LOOP_OUT,
        CD_RET
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucw_t;

    typedef struct packed {
        logic in_acc;
        logic full;
        logic last;
        logic fill56;
        logic round_done;
        logic out_done;
    } stat_t;

    localparam step_t STEP_ACC  = 4'd0;
    localparam step_t STEP_FILL = 4'd5;
    localparam step_t STEP_LEN  = 4'd9;
    localparam step_t STEP_COMP = 4'd13;

    localparam ucw_t UCODE [SCHED_DEPTH] = '{
        '{op: OP_ACC,    cond: CD_WAIT_IN,      target: STEP_ACC},
        '{op: OP_NOP,    cond: CD_CALL_FULL,    target: STEP_COMP},
        '{op: OP_NOP,    cond: CD_JMP_NOT_LAST, target: STEP_ACC},
        '{op: OP_PAD80,  cond: CD_NEXT,         target: STEP_ACC},
        '{op: OP_NOP,    cond: CD_CALL_FULL,    target: STEP_COMP},
        '{op: OP_NOP,    cond: CD_JMP_FILL56,   target: STEP_LEN},
        '{op: OP_ZWORD,  cond: CD_NEXT,         target: STEP_ACC},
        '{op: OP_NOP,    cond: CD_CALL_FULL,    target: STEP_COMP},
        '{op: OP_NOP,    cond: CD_JUMP,         target: STEP_FILL},
        '{op: OP_LEN_HI, cond: CD_NEXT,         target: STEP_ACC},
        '{op: OP_LEN_LO, cond: CD_NEXT,         target: STEP_ACC},
        '{op: OP_NOP,    cond: CD_CALL_FULL,    target: STEP_COMP},
        '{op: OP_OUT,    cond: CD_LOOP_OUT,     target: STEP_ACC},
        '{op: OP_LOAD,   cond: CD_NEXT,         target: STEP_ACC},
        '{op: OP_ROUND,  cond: CD_LOOP_ROUND,   target: STEP_ACC},
        '{op: OP_ADD,    cond: CD_RET,          target: STEP_ACC}
    };

    function automatic word_t rotl1(word_t x);
        return {x[30:0], x[31]};
    endfunction

    function automatic word_t rotl5(word_t x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic word_t rotl30(word_t x);
        return {x[1:0], x[31:2]};
    endfunction

    function automatic word_t round_f(round_t r, word_t b, word_t c, word_t d);
        word_t f;
        if (r < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (r < 7'd40) begin
            f = b ^ c ^ d;
        end else if (r < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic word_t round_k(round_t r);
        word_t k;
        if (r < 7'd20) begin
            k = 32'h5A82_7999;
        end else if (r < 7'd40) begin
            k = 32'h6ED9_EBA1;
        end else if (r < 7'd60) begin
            k = 32'h8F1B_BCDC;
        end else begin
            k = 32'hCA62_C1D6;
        end
        return k;
    endfunction

endpackage

FILE: src/sha1md_ucode.sv
// ----------------------------------------------------------------------------
// SHA-1 microcode sequencer
// Step counter over the control ROM, with conditional jumps and a one-deep
// return register for the compression subroutine.
// ----------------------------------------------------------------------------
module sha1md_ucode (
    input  logic               aclk,
    input  logic               aresetn,
    input  sha1md_pkg::stat_t  stat,
    output sha1md_pkg::ucw_t   ctrl
);
    import sha1md_pkg::*;

    step_t pc_reg, pc_next;
    step_t ret_reg, ret_next;
    step_t pc_inc;

    assign ctrl   = UCODE[pc_reg];
    assign pc_inc = pc_reg + 4'd1;

    always_comb begin
        pc_next  = pc_inc;
        ret_next = ret_reg;
        unique case (ctrl.cond)
            CD_NEXT:         pc_next = pc_inc;
            CD_JUMP:         pc_next = ctrl.target;
            CD_WAIT_IN:      pc_next = stat.in_acc ? pc_inc : pc_reg;
            CD_CALL_FULL: begin
                if (stat.full) begin
                    pc_next  = ctrl.target;
                    ret_next = pc_inc;
                end
            end
            CD_JMP_NOT_LAST: pc_next = stat.last ? pc_inc : ctrl.target;
            CD_JMP_FILL56:   pc_next = stat.fill56 ? ctrl.target : pc_inc;
            CD_LOOP_ROUND:   pc_next = stat.round_done ? pc_inc : pc_reg;
            CD_LOOP_OUT:     pc_next = stat.out_done ? ctrl.target : pc_reg;
            CD_RET:          pc_next = ret_reg;
            default:         pc_next = STEP_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= STEP_ACC;
            ret_reg <= STEP_ACC;
        end else begin
            pc_reg  <= pc_next;
            ret_reg <= ret_next;
        end
    end

endmodule

FILE: src/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Microcoded SHA-1 engine: byte packer, 16-word schedule line, one round
// per cycle, padding and length append, five-word digest output.
// ----------------------------------------------------------------------------
// Usage:
//   s_ side takes the message as big-endian 32-bit words with a byte count;
//   s_tlast marks the final word (it may carry 0..4 bytes). One word is
//   taken at a time: s_tready is high only in the accept step.
//   A word that closes a 64-byte block starts a compression (load, 80
//   rounds at one per cycle, chain add), and no further word is taken
//   until that compression has finished.
//   After the last word come the 0x80 marker, the zero words of padding
//   and the length, then one or two final compressions follow, then five
//   digest words leave on m_, index 0 (most significant) first, m_tlast
//   on index 4.
//   Digest words sit in an output register; when m_tready is low the
//   sequencer waits on the next word, and the register holds. After the
//   fifth word is loaded the chain returns to the initial values and the
//   next message can start while that word still waits.
//   Reset (aresetn low, synchronous) restarts the sequencer, clears the
//   byte and bit counts and loads the initial chain values.
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count, zero fill
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast    // last_word
);
    import sha1md_pkg::*;

    ucw_t  ctrl;
    stat_t stat;

    sha1md_ucode u_ucode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    word_t       sched_reg [SCHED_DEPTH];
    word_t       sched_next[SCHED_DEPTH];
    word_t       h_reg     [CHAIN_DEPTH];
    word_t       h_next    [CHAIN_DEPTH];
    word_t       wv_reg    [CHAIN_DEPTH];
    word_t       wv_next   [CHAIN_DEPTH];
    word_t       part_reg, part_next;
    logic [1:0]  pcnt_reg, pcnt_next;
    logic [4:0]  wcnt_reg, wcnt_next;
    logic [63:0] bits_reg, bits_next;
    round_t      rnd_reg, rnd_next;
    logic        last_reg, last_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        mvalid_reg, mvalid_next;
    word_t       mdata_reg, mdata_next;
    logic [2:0]  midx_reg, midx_next;
    logic        mlast_reg, mlast_next;

    logic        in_acc;
    logic        out_load;
    logic [2:0]  cnt_in;
    logic [2:0]  src_cnt;
    word_t       src_data;
    word_t       part_m;
    word_t       data_m;
    logic [63:0] new64;
    logic [63:0] comb64;
    logic [3:0]  total;
    logic        shift_en;
    logic        word_in;
    word_t       shift_word;
    word_t       w;
    word_t       t;

    assign s_tready = (ctrl.op == OP_ACC);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (ctrl.op == OP_OUT) && (!mvalid_reg || m_tready);

    assign stat.in_acc     = in_acc;
    assign stat.full       = (wcnt_reg == BLOCK_WORDS);
    assign stat.last       = last_reg;
    assign stat.fill56     = (wcnt_reg == FILL_STOP_WORDS) && (pcnt_reg == 2'd0);
    assign stat.round_done = (rnd_reg == LAST_ROUND);
    assign stat.out_done   = out_load && (oidx_reg == LAST_INDEX);

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {5'b0, midx_reg, mdata_reg};
    assign m_tlast  = mlast_reg;

    // byte packer: open bytes are left-aligned, unused bytes kept zero by masking
    always_comb begin
        cnt_in   = (s_tdata[34:32] > MAX_BYTES) ? MAX_BYTES : s_tdata[34:32];
        src_data = (ctrl.op == OP_PAD80) ? PAD_WORD : s_tdata[31:0];
        src_cnt  = (ctrl.op == OP_PAD80) ? 3'd1 : cnt_in;
        part_m   = part_reg & ~(32'hFFFF_FFFF >> {pcnt_reg, 3'b000});
        data_m   = src_data & ~(32'hFFFF_FFFF >> {src_cnt, 3'b000});
        new64    = {data_m, 32'h0} >> {pcnt_reg, 3'b000};
        comb64   = {part_m, 32'h0} | new64;
        total    = {2'b00, pcnt_reg} + {1'b0, src_cnt};
    end

    // schedule word and round sum
    always_comb begin
        if (rnd_reg < LOAD_ROUNDS) begin
            w = sched_reg[0];
        end else begin
            w = rotl1(sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0]);
        end
        t = rotl5(wv_reg[0]) + round_f(rnd_reg, wv_reg[1], wv_reg[2], wv_reg[3])
            + wv_reg[4] + round_k(rnd_reg) + w;
    end

    always_comb begin
        part_next   = part_reg;
        pcnt_next   = pcnt_reg;
        wcnt_next   = wcnt_reg;
        bits_next   = bits_reg;
        rnd_next    = rnd_reg;
        last_next   = last_reg;
        oidx_next   = oidx_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        midx_next   = midx_reg;
        mlast_next  = mlast_reg;
        h_next      = h_reg;
        wv_next     = wv_reg;
        shift_en    = 1'b0;
        word_in     = 1'b0;
        shift_word  = part_m;

        if (m_tready) begin
            mvalid_next = 1'b0;
        end

        case (ctrl.op)
            OP_ACC, OP_PAD80: begin
                if (in_acc || ctrl.op == OP_PAD80) begin
                    pcnt_next = total[1:0];
                    if (total[2]) begin
                        word_in    = 1'b1;
                        shift_word = comb64[63:32];
                        part_next  = comb64[31:0];
                    end else begin
                        part_next  = comb64[63:32];
                    end
                    if (ctrl.op == OP_ACC) begin
                        bits_next = bits_reg + {58'b0, cnt_in, 3'b000};
                        last_next = s_tlast;
                    end
                end
            end
            OP_ZWORD: begin
                word_in    = 1'b1;
                shift_word = part_m;
                pcnt_next  = 2'd0;
            end
            OP_LEN_HI: begin
                word_in    = 1'b1;
                shift_word = bits_reg[63:32];
            end
            OP_LEN_LO: begin
                word_in    = 1'b1;
                shift_word = bits_reg[31:0];
            end
            OP_LOAD: begin
                wv_next  = h_reg;
                rnd_next = '0;
            end
            OP_ROUND: begin
                shift_en   = 1'b1;
                shift_word = w;
                wv_next[0] = t;
                wv_next[1] = wv_reg[0];
                wv_next[2] = rotl30(wv_reg[1]);
                wv_next[3] = wv_reg[2];
                wv_next[4] = wv_reg[3];
                rnd_next   = (rnd_reg == LAST_ROUND) ? '0 : rnd_reg + 7'd1;
            end
            OP_ADD: begin
                for (int i = 0; i < CHAIN_DEPTH; i++) begin
                    h_next[i] = h_reg[i] + wv_reg[i];
                end
                wcnt_next = '0;
            end
            OP_OUT: begin
                if (out_load) begin
                    mvalid_next = 1'b1;
                    mdata_next  = h_reg[oidx_reg];
                    midx_next   = oidx_reg;
                    mlast_next  = (oidx_reg == LAST_INDEX);
                    oidx_next   = oidx_reg + 3'd1;
                    if (oidx_reg == LAST_INDEX) begin
                        // digest out: back to a fresh message
                        oidx_next = '0;
                        h_next    = SHA1_IV;
                        bits_next = '0;
                        pcnt_next = 2'd0;
                        wcnt_next = '0;
                        last_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        if (word_in) begin
            shift_en  = 1'b1;
            wcnt_next = wcnt_reg + 5'd1;
        end

        sched_next = sched_reg;
        if (shift_en) begin
            for (int i = 0; i < SCHED_DEPTH - 1; i++) begin
                sched_next[i] = sched_reg[i + 1];
            end
            sched_next[SCHED_DEPTH - 1] = shift_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg      <= SHA1_IV;
            pcnt_reg   <= 2'd0;
            wcnt_reg   <= '0;
            bits_reg   <= '0;
            rnd_reg    <= '0;
            last_reg   <= 1'b0;
            oidx_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            h_reg      <= h_next;
            pcnt_reg   <= pcnt_next;
            wcnt_reg   <= wcnt_next;
            bits_reg   <= bits_next;
            rnd_reg    <= rnd_next;
            last_reg   <= last_next;
            oidx_reg   <= oidx_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sched_reg <= sched_next;
        wv_reg    <= wv_next;
        part_reg  <= part_next;
        mdata_reg <= mdata_next;
        midx_reg  <= midx_next;
        mlast_reg <= mlast_next;
    end

    // block never overfills: compression always runs before more words come in
    a_wcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wcnt_reg <= BLOCK_WORDS)
        else $error("block word count above 16");

    // round counter is only away from zero inside the round loop
    a_rnd_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (rnd_reg != 7'd0) |-> (ctrl.op == OP_ROUND))
        else $error("round counter busy outside round step");

    // last flag only on the fifth digest word
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && mlast_reg) |-> (midx_reg == LAST_INDEX))
        else $error("m_tlast on wrong digest index");

    // no input taken while a block waits for compression
    a_full_no_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (wcnt_reg == BLOCK_WORDS) |-> !s_tready)
        else $error("input accepted with full block");

endmodule
